// ===== rtl/core/rational_arithmetic_unit_defines.svh =====
// Assertion macros shared by the rational arithmetic unit checker.
// Depends on nothing; included by the checker file only.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RAU_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("rational unit check failed");

// Next-cycle implication checked on every rising clock edge outside reset.
`define RAU_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("rational unit check failed");

`endif

// ===== rtl/core/rau_pkg.sv =====
// Shared types and constants for the rational arithmetic unit.
// No dependencies; imported by every module of the block.
package rau_pkg;

    localparam int InW   = 31;
    localparam int ProdW = 62;
    localparam int NumW  = 63;
    localparam int DenW  = 61;
    localparam int MagW  = 62;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    // Classified transaction passed from the front part to the back part.
    typedef struct packed {
        logic             err;
        logic [1:0]       op;
        logic signed [InW-1:0] p;
        logic signed [InW-1:0] q;
        logic signed [InW-1:0] r;
        logic signed [InW-1:0] s;
        logic signed [InW-1:0] t;
        logic signed [InW-1:0] u;
    } rau_cmd_t;

endpackage

// ===== rtl/core/rau_front.sv =====
// Front part: accepts a transaction, classifies error cases and picks operands.
// Depends on rau_pkg.
module rau_front
    import rau_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [1:0]            operation,
    input  logic signed [InW-1:0] a_num,
    input  logic signed [InW-1:0] a_den,
    input  logic signed [InW-1:0] b_num,
    input  logic signed [InW-1:0] b_den,
    input  logic                  busy,
    output logic                  cmd_valid,
    output rau_cmd_t              cmd,
    input  logic                  cmd_take
);

    logic     valid_reg, valid_next;
    rau_cmd_t cmd_reg, cmd_next;
    logic     accept;

    assign accept = start && !busy;

    // Operands are arranged so that the back part forms p*q op r*s (p*q alone for multiply and divide) over t*u.
    always_comb
    begin
        cmd_next    = cmd_reg;
        valid_next  = valid_reg;
        if (cmd_take)
            valid_next = 1'b0;
        if (accept)
        begin
            valid_next   = 1'b1;
            cmd_next.op  = operation;
            cmd_next.err = (a_den == '0) || (b_den == '0)
                           || (operation == OP_DIV && b_num == '0);
            cmd_next.p   = a_num;
            cmd_next.q   = (operation == OP_MUL) ? b_num : b_den;
            cmd_next.r   = b_num;
            cmd_next.s   = (operation == OP_DIV) ? b_num : a_den;
            cmd_next.t   = a_den;
            cmd_next.u   = (operation == OP_DIV) ? b_num : b_den;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

endmodule

// ===== rtl/core/rau_back.sv =====
// Back part: cross products, binary gcd, reduction by shift-subtract division.
// Depends on rau_pkg.
module rau_back
    import rau_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cmd_valid,
    input  rau_cmd_t               cmd,
    output logic                   cmd_take,
    output logic                   done,
    output logic signed [NumW-1:0] res_num,
    output logic [DenW-1:0]        res_den,
    output logic                   error
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL1 = 3'd1;
    localparam logic [2:0] S_MUL2 = 3'd2;
    localparam logic [2:0] S_PREP = 3'd3;
    localparam logic [2:0] S_GCD  = 3'd4;
    localparam logic [2:0] S_DIVN = 3'd5;
    localparam logic [2:0] S_DIVD = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    localparam int CntW = $clog2(MagW + 1);

    logic [2:0]             state_reg, state_next;
    rau_cmd_t               c_reg, c_next;
    logic signed [ProdW-1:0] pa_reg, pa_next, pb_reg, pb_next, dp_reg, dp_next;
    logic signed [NumW-1:0] num_reg, num_next;
    logic                   neg_reg, neg_next;
    logic [MagW-1:0]        x_reg, x_next, y_reg, y_next;
    logic [MagW-1:0]        un_reg, un_next, ud_reg, ud_next;
    logic [CntW-1:0]        k_reg, k_next, cnt_reg, cnt_next;
    logic [MagW-1:0]        quo_reg, quo_next, rem_reg, rem_next, dv_reg, dv_next;
    logic                   done_reg, done_next, err_reg, err_next;
    logic signed [NumW-1:0] rn_reg, rn_next;
    logic [DenW-1:0]        rd_reg, rd_next;
    logic [MagW-1:0]        diff, rem_sh;
    logic signed [NumW-1:0] sum;

    assign sum    = (c_reg.op == OP_SUB)
                    ? (NumW'(pa_reg) - NumW'(pb_reg)) : (NumW'(pa_reg) + NumW'(pb_reg));
    assign diff   = (x_reg > y_reg) ? (x_reg - y_reg) : (y_reg - x_reg);
    assign rem_sh = {rem_reg[MagW-2:0], quo_reg[MagW-1]};

    always_comb
    begin
        state_next = state_reg;
        c_next = c_reg; pa_next = pa_reg; pb_next = pb_reg; dp_next = dp_reg;
        num_next = num_reg; neg_next = neg_reg; x_next = x_reg; y_next = y_reg;
        un_next = un_reg; ud_next = ud_reg; k_next = k_reg; cnt_next = cnt_reg;
        quo_next = quo_reg; rem_next = rem_reg; dv_next = dv_reg;
        done_next = 1'b0; err_next = err_reg; rn_next = rn_reg; rd_next = rd_reg;
        cmd_take = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    c_next     = cmd;
                    state_next = S_MUL1;
                end
            end
            S_MUL1:
            begin
                pa_next    = ProdW'(c_reg.p) * ProdW'(c_reg.q);
                pb_next    = ProdW'(c_reg.r) * ProdW'(c_reg.s);
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                // Denominator: a_den*b_den, or a_den*b_num for division.
                dp_next    = ProdW'(c_reg.t) * ProdW'(c_reg.u);
                state_next = S_PREP;
            end
            S_PREP:
            begin
                num_next = (c_reg.op == OP_MUL || c_reg.op == OP_DIV) ? NumW'(pa_reg) : sum;
                state_next = S_GCD;
                if (c_reg.err)
                begin
                    err_next = 1'b1; rn_next = '0; rd_next = '0; state_next = S_OUT;
                end
                else
                begin
                    err_next = 1'b0;
                    if (num_next == '0)
                    begin
                        rn_next = '0; rd_next = DenW'(1); state_next = S_OUT;
                    end
                end
                neg_next = num_next[NumW-1] ^ dp_reg[ProdW-1];
                un_next  = num_next[NumW-1] ? MagW'(-num_next) : MagW'(num_next);
                ud_next  = dp_reg[ProdW-1] ? MagW'(-dp_reg) : MagW'(dp_reg);
                x_next   = un_next;
                y_next   = ud_next;
                k_next   = '0;
            end
            S_GCD:
            begin
                // Binary gcd: one step per cycle.
                if (x_reg == y_reg)
                begin
                    dv_next    = x_reg << k_reg;
                    quo_next   = un_reg; rem_next = '0; cnt_next = '0;
                    state_next = S_DIVN;
                end
                else if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1; y_next = y_reg >> 1; k_next = k_reg + 1'b1;
                end
                else if (!x_reg[0])
                    x_next = x_reg >> 1;
                else if (!y_reg[0])
                    y_next = y_reg >> 1;
                else if (x_reg > y_reg)
                    x_next = diff >> 1;
                else
                    y_next = diff >> 1;
            end
            S_DIVN, S_DIVD:
            begin
                // Restoring division, one quotient bit per cycle.
                if (rem_sh >= dv_reg)
                begin
                    rem_next = rem_sh - dv_reg;
                    quo_next = {quo_reg[MagW-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[MagW-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(MagW - 1))
                begin
                    cnt_next = '0;
                    rem_next = '0;
                    if (state_reg == S_DIVN)
                    begin
                        rn_next    = neg_reg ? -NumW'(quo_next) : NumW'(quo_next);
                        quo_next   = ud_reg;
                        state_next = S_DIVD;
                    end
                    else
                    begin
                        rd_next    = DenW'(quo_next);
                        state_next = S_OUT;
                    end
                end
            end
            S_OUT:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg <= c_next; pa_reg <= pa_next; pb_reg <= pb_next; dp_reg <= dp_next;
        num_reg <= num_next; neg_reg <= neg_next; x_reg <= x_next; y_reg <= y_next;
        un_reg <= un_next; ud_reg <= ud_next; k_reg <= k_next; cnt_reg <= cnt_next;
        quo_reg <= quo_next; rem_reg <= rem_next; dv_reg <= dv_next;
        err_reg <= err_next; rn_reg <= rn_next; rd_reg <= rd_next;
    end

    assign done    = done_reg;
    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign error   = err_reg;

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: front part, one-entry queue, back part.
// Depends on rau_pkg, rau_front and rau_back.
//
// A transaction is taken when start is high and busy is low. Hand-over and the
// cross products pass the front register and the IDLE, MUL1, MUL2 and PREP
// states; then come the binary gcd steps and the shared shift-subtract divider,
// first for the numerator and then for the denominator, and done is registered
// from the OUT state. An error or a zero result skips the gcd and the divider
// and goes from PREP straight to OUT. The result is shown for one cycle with
// done high and cannot be held off. A zero denominator, or division by a zero
// numerator, gives error with 0/0; a zero result is given as 0/1.
module rational_arithmetic_unit
    import rau_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [1:0]             operation,
    input  logic signed [InW-1:0]  a_num,
    input  logic signed [InW-1:0]  a_den,
    input  logic signed [InW-1:0]  b_num,
    input  logic signed [InW-1:0]  b_den,
    output logic                   done,
    output logic signed [NumW-1:0] res_num,
    output logic [DenW-1:0]        res_den,
    output logic                   error
);

    logic     cmd_valid, cmd_take;
    rau_cmd_t cmd;

    // The queue holds one classified transaction; a second waits for it to drain.
    assign busy = cmd_valid && !cmd_take;

    rau_front u_front (
        .clk(clk), .rst_n(rst_n), .start(start), .operation(operation),
        .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .busy(busy), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_take(cmd_take)
    );

    rau_back u_back (
        .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd),
        .cmd_take(cmd_take), .done(done),
        .res_num(res_num), .res_den(res_den), .error(error)
    );

endmodule

// ===== rtl/core/rau_checker.sv =====
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg and rational_arithmetic_unit_defines.svh.
`include "rational_arithmetic_unit_defines.svh"

module rau_checker
    import rau_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   done,
    input logic signed [NumW-1:0] res_num,
    input logic [DenW-1:0]        res_den,
    input logic                   error
);

    `RAU_ASSERT_IMP(a_err_zero, clk, rst_n, done && error, res_num == '0 && res_den == '0)
    `RAU_ASSERT_IMP(a_den_pos, clk, rst_n, done && !error, res_den != '0)
    `RAU_ASSERT_NXT(a_done_pulse, clk, rst_n, done, !done)
    `RAU_ASSERT_NXT(a_zero_one, clk, rst_n, done && !error && res_num == '0,
                    $past(res_den) == DenW'(1))

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .clk(clk), .rst_n(rst_n), .done(done),
    .res_num(res_num), .res_den(res_den), .error(error)
);
